// ===== rtl/ifrd_pkg.sv =====
// Shared types and constants of the information frame receiver and destuffer.
`default_nettype none

package ifrd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1024;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W = 11;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLAG = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC = 8'h5D;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_NEW = 2'd0,
        VERDICT_DUP = 2'd1,
        VERDICT_REJ = 2'd2
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADDRESS_COMMAND = 3'd0,
        REG_CONTROL_SEQ0 = 3'd1,
        REG_CONTROL_SEQ1 = 3'd2,
        REG_READY_CODE0 = 3'd3,
        REG_READY_CODE1 = 3'd4,
        REG_REJECT_CODE0 = 3'd5,
        REG_REJECT_CODE1 = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address_command;
        logic [BYTE_W-1:0] control_seq0;
        logic [BYTE_W-1:0] control_seq1;
        logic [BYTE_W-1:0] ready_code0;
        logic [BYTE_W-1:0] ready_code1;
        logic [BYTE_W-1:0] reject_code0;
        logic [BYTE_W-1:0] reject_code1;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        verdict_t          verdict;
        logic [BYTE_W-1:0] response_control;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ifrd_cfg_regs.sv =====
// Configuration register file of the frame receiver.
`default_nettype none

module ifrd_cfg_regs
    import ifrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_command <= 8'd3;
            cfg_reg.control_seq0 <= 8'd0;
            cfg_reg.control_seq1 <= 8'd64;
            cfg_reg.ready_code0 <= 8'd5;
            cfg_reg.ready_code1 <= 8'd133;
            cfg_reg.reject_code0 <= 8'd1;
            cfg_reg.reject_code1 <= 8'd129;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ADDRESS_COMMAND: cfg_reg.address_command <= cfg_data;
                REG_CONTROL_SEQ0: cfg_reg.control_seq0 <= cfg_data;
                REG_CONTROL_SEQ1: cfg_reg.control_seq1 <= cfg_data;
                REG_READY_CODE0: cfg_reg.ready_code0 <= cfg_data;
                REG_READY_CODE1: cfg_reg.ready_code1 <= cfg_data;
                REG_REJECT_CODE0: cfg_reg.reject_code0 <= cfg_data;
                REG_REJECT_CODE1: cfg_reg.reject_code1 <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifrd_parser.sv =====
// Input register, frame state and per-byte parsing and destuffing logic.
`default_nettype none

module ifrd_parser
    import ifrd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              seq_reg, seq_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_seq_reg, last_seq_next;

    logic              fire;
    logic              take;
    logic [BYTE_W-1:0] take_byte;
    logic [BYTE_W-1:0] ctrl_sel;
    logic              bad;
    logic [EXT_W-1:0]  count_ext;
    logic              emit;

    assign fire = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || fire;
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg <= '0;
            xor_reg <= '0;
            seq_reg <= 1'b0;
            err_reg <= 1'b0;
            count_reg <= '0;
            last_seq_reg <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            esc_reg <= esc_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg <= held_byte_next;
            xor_reg <= xor_next;
            seq_reg <= seq_next;
            err_reg <= err_next;
            count_reg <= count_next;
            last_seq_reg <= last_seq_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        esc_next = esc_reg;
        held_valid_next = held_valid_reg;
        held_byte_next = held_byte_reg;
        xor_next = xor_reg;
        seq_next = seq_reg;
        err_next = err_reg;
        count_next = count_reg;
        last_seq_next = last_seq_reg;
        take = 1'b0;
        take_byte = in_byte_reg;
        emit = 1'b0;
        res = '0;
        ctrl_sel = seq_reg ? cfg.control_seq1 : cfg.control_seq0;
        bad = err_reg || esc_reg || !held_valid_reg || (held_byte_reg != xor_reg);

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == FLAG_BYTE)
                begin
                    phase_next = PH_FLAG;
                end
            end
            PH_FLAG:
            begin
                if (in_byte_reg != FLAG_BYTE)
                begin
                    phase_next = (in_byte_reg == cfg.address_command) ? PH_ADDR : PH_HUNT;
                end
            end
            PH_ADDR:
            begin
                priority if (in_byte_reg == FLAG_BYTE)
                begin
                    phase_next = PH_FLAG;
                end
                else if (in_byte_reg == cfg.control_seq0)
                begin
                    seq_next = 1'b0;
                    phase_next = PH_CTRL;
                end
                else if (in_byte_reg == cfg.control_seq1)
                begin
                    seq_next = 1'b1;
                    phase_next = PH_CTRL;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CTRL:
            begin
                priority if (in_byte_reg == (cfg.address_command ^ ctrl_sel))
                begin
                    phase_next = PH_DATA;
                    esc_next = 1'b0;
                    held_valid_next = 1'b0;
                    held_byte_next = '0;
                    xor_next = '0;
                    err_next = 1'b0;
                    count_next = '0;
                end
                else if (in_byte_reg == FLAG_BYTE)
                begin
                    phase_next = PH_FLAG;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA:
            begin
                priority if (in_byte_reg == FLAG_BYTE)
                begin
                    emit = 1'b1;
                    res.kind = 1'b1;
                    res.payload_length = count_ext[LEN_W-1:0];
                    if (bad)
                    begin
                        res.verdict = VERDICT_REJ;
                        res.response_control = seq_reg ? cfg.reject_code1
                                                       : cfg.reject_code0;
                    end
                    else
                    begin
                        res.verdict = (seq_reg == last_seq_reg) ? VERDICT_DUP
                                                                : VERDICT_NEW;
                        last_seq_next = seq_reg;
                        res.response_control = seq_reg ? cfg.ready_code0
                                                       : cfg.ready_code1;
                    end
                    phase_next = PH_HUNT;
                    esc_next = 1'b0;
                    held_valid_next = 1'b0;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    priority if (in_byte_reg == ESC_FLAG)
                    begin
                        take = 1'b1;
                        take_byte = FLAG_BYTE;
                    end
                    else if (in_byte_reg == ESC_ESC)
                    begin
                        take = 1'b1;
                        take_byte = ESC_BYTE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (in_byte_reg == ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        if (take && !err_reg)
        begin
            if (!held_valid_reg)
            begin
                held_byte_next = take_byte;
                held_valid_next = 1'b1;
            end
            else if (count_reg >= CNT_W'(MAX_PAYLOAD))
            begin
                err_next = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                res.payload_byte = held_byte_reg;
                xor_next = xor_reg ^ held_byte_reg;
                count_next = count_reg + CNT_W'(1);
                held_byte_next = take_byte;
            end
        end

        res_valid = fire && emit;
    end

endmodule

`default_nettype wire

// ===== rtl/ifrd_out_reg.sv =====
// Result register between the parsing logic and the output channel.
`default_nettype none

module ifrd_out_reg
    import ifrd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    out_valid_reg;
    result_t out_res_reg;

    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/info_frame_receiver_destuffer_unit.sv =====
// Top level of the information frame receiver and destuffer.
//
//  Channel  Handshake               Payload
//  in       in_valid / in_ready     rx_byte
//  out      out_valid / out_ready   kind, payload_byte, verdict, response_control,
//                                   payload_length
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat per cycle is taken on the input unless the output stalls; a byte is held
// in the input register, parsed from there, and any result beat that it yields is
// registered in the result register before it appears on the output.
// Reset puts the receiver in flag hunt with the last accepted sequence at one.
// A stalled output holds its beat and backs up through both registers.
`default_nettype none

module info_frame_receiver_destuffer_unit
    import ifrd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic [BYTE_W-1:0]         payload_byte,
    output logic [1:0]                verdict,
    output logic [BYTE_W-1:0]         response_control,
    output logic [LEN_W-1:0]          payload_length,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    cfg_t    cfg;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    ifrd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifrd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ifrd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign verdict = out_res.verdict;
    assign response_control = out_res.response_control;
    assign payload_length = out_res.payload_length;

endmodule

`default_nettype wire

// ===== tb/frame_verdict_checker.sv =====
// Checker that predicts the receiver's payload and verdict beats and compares them.
module frame_verdict_checker
    import ifrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 kind,
    input  logic [BYTE_W-1:0]    payload_byte,
    input  logic [1:0]           verdict,
    input  logic [BYTE_W-1:0]    response_control,
    input  logic [LEN_W-1:0]     payload_length,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   awaited,
    output int                   mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t              setting;
    phase_t            hunt_phase;
    logic              esc_open;
    logic              held_ok;
    logic [BYTE_W-1:0] held;
    logic [BYTE_W-1:0] xor_sum;
    logic              seq;
    logic              frame_bad;
    int unsigned       count;
    logic              last_seq;
    result_t           awaited_beats[$];
    result_t           want;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s got %0h, wanted %0h", $realtime, what, got, exp);
        mismatches++;
    endtask

    task automatic take_destuffed(input logic [BYTE_W-1:0] d);
        result_t r;
        if (!frame_bad)
        begin
            if (held_ok && count >= MAX_PAYLOAD_DEF)
                frame_bad = 1'b1;
            else
            begin
                if (held_ok)
                begin
                    r = '0;
                    r.payload_byte = held;
                    awaited_beats.push_back(r);
                    xor_sum = xor_sum ^ held;
                    count++;
                end
                held = d;
                held_ok = 1'b1;
            end
        end
    endtask

    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] ctrl;
        result_t r;
        unique case (hunt_phase)
            PH_HUNT:
                if (b == FLAG_BYTE)
                    hunt_phase = PH_FLAG;
            PH_FLAG:
                if (b != FLAG_BYTE)
                    hunt_phase = (b == setting.address_command) ? PH_ADDR : PH_HUNT;
            PH_ADDR:
                if (b == FLAG_BYTE)
                    hunt_phase = PH_FLAG;
                else if (b == setting.control_seq0)
                begin
                    seq = 1'b0;
                    hunt_phase = PH_CTRL;
                end
                else if (b == setting.control_seq1)
                begin
                    seq = 1'b1;
                    hunt_phase = PH_CTRL;
                end
                else
                    hunt_phase = PH_HUNT;
            PH_CTRL:
            begin
                ctrl = seq ? setting.control_seq1 : setting.control_seq0;
                if (b == (setting.address_command ^ ctrl))
                begin
                    hunt_phase = PH_DATA;
                    esc_open = 1'b0;
                    held_ok = 1'b0;
                    held = '0;
                    xor_sum = '0;
                    frame_bad = 1'b0;
                    count = 0;
                end
                else if (b == FLAG_BYTE)
                    hunt_phase = PH_FLAG;
                else
                    hunt_phase = PH_HUNT;
            end
            PH_DATA:
                if (b == FLAG_BYTE)
                begin
                    r = '0;
                    r.kind = 1'b1;
                    if (frame_bad || esc_open || !held_ok || held != xor_sum)
                    begin
                        r.verdict = VERDICT_REJ;
                        r.response_control = seq ? setting.reject_code1 : setting.reject_code0;
                    end
                    else
                    begin
                        r.verdict = (seq == last_seq) ? VERDICT_DUP : VERDICT_NEW;
                        last_seq = seq;
                        r.response_control = seq ? setting.ready_code0 : setting.ready_code1;
                    end
                    r.payload_length = count[LEN_W-1:0];
                    awaited_beats.push_back(r);
                    hunt_phase = PH_HUNT;
                    esc_open = 1'b0;
                    held_ok = 1'b0;
                end
                else if (esc_open)
                begin
                    esc_open = 1'b0;
                    if (b == ESC_FLAG)
                        take_destuffed(FLAG_BYTE);
                    else if (b == ESC_ESC)
                        take_destuffed(ESC_BYTE);
                    else
                        frame_bad = 1'b1;
                end
                else if (b == ESC_BYTE)
                    esc_open = 1'b1;
                else
                    take_destuffed(b);
            default:
                hunt_phase = PH_HUNT;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting = '{8'h03, 8'h00, 8'h40, 8'h05, 8'h85, 8'h01, 8'h81};
            hunt_phase = PH_HUNT;
            esc_open = 1'b0;
            held_ok = 1'b0;
            held = '0;
            xor_sum = '0;
            seq = 1'b0;
            frame_bad = 1'b0;
            count = 0;
            last_seq = 1'b1;
            awaited_beats.delete();
            awaited = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_beats.size() == 0)
                    report_mismatch("beat with nothing awaited, kind", 16'(kind), 16'h0);
                else
                begin
                    want = awaited_beats.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", 16'(kind), 16'(want.kind));
                    if (payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", 16'(payload_byte),
                                        16'(want.payload_byte));
                    if (verdict !== want.verdict)
                        report_mismatch("verdict", 16'(verdict), 16'(want.verdict));
                    if (response_control !== want.response_control)
                        report_mismatch("response_control", 16'(response_control),
                                        16'(want.response_control));
                    if (payload_length !== want.payload_length)
                        report_mismatch("payload_length", 16'(payload_length),
                                        16'(want.payload_length));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ADDRESS_COMMAND: setting.address_command = cfg_data;
                    REG_CONTROL_SEQ0:    setting.control_seq0 = cfg_data;
                    REG_CONTROL_SEQ1:    setting.control_seq1 = cfg_data;
                    REG_READY_CODE0:     setting.ready_code0 = cfg_data;
                    REG_READY_CODE1:     setting.ready_code1 = cfg_data;
                    REG_REJECT_CODE0:    setting.reject_code0 = cfg_data;
                    REG_REJECT_CODE1:    setting.reject_code1 = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            awaited = awaited_beats.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the frame receiver testbench: clock, reset, byte stream stimulus and verdict.
module tb
    import ifrd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef enum logic [3:0] {
        FLAW_NONE,
        FLAW_ADDRESS,
        FLAW_CTRL_FLAG,
        FLAW_BCC1,
        FLAW_BCC1_FLAG,
        FLAW_BCC2,
        FLAW_BAD_ESCAPE,
        FLAW_ESCAPE_FLAG,
        FLAW_EMPTY
    } flaw_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [BYTE_W-1:0]    payload_byte;
    logic [1:0]           verdict;
    logic [BYTE_W-1:0]    response_control;
    logic [LEN_W-1:0]     payload_length;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ADDRESS_COMMAND;
    logic [BYTE_W-1:0]    cfg_data = '0;
    int                   awaited;
    int                   mismatches;

    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    bit          hasty = 1'b0;
    bit          sink_hasty = 1'b0;
    logic        tx_seq = 1'b0;
    cfg_t        cur = '{8'h03, 8'h00, 8'h40, 8'h05, 8'h85, 8'h01, 8'h81};

    info_frame_receiver_destuffer_unit uut (.*);

    frame_verdict_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("info_frame_receiver_destuffer_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if ($urandom_range(0, 15) == 0)
                    sink_hasty = !sink_hasty;
                hold = sink_hasty ? 0 : $urandom_range(0, 11);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = hasty ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_stuffed(input logic [BYTE_W-1:0] b);
        if (b == FLAG_BYTE)
        begin
            send_byte(ESC_BYTE);
            send_byte(ESC_FLAG);
        end
        else if (b == ESC_BYTE)
        begin
            send_byte(ESC_BYTE);
            send_byte(ESC_ESC);
        end
        else
            send_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] pick_data();
        unique case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return ESC_FLAG;
            3:       return ESC_ESC;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input logic seq, input int len, input flaw_t flaw);
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] d;
        int cut;
        ctrl = seq ? cur.control_seq1 : cur.control_seq0;
        sum = '0;
        cut = $urandom_range(0, len);
        repeat ($urandom_range(1, 3)) send_byte(FLAG_BYTE);
        if (flaw == FLAW_ADDRESS)
            send_byte(cur.address_command ^ (8'h01 << $urandom_range(0, 7)));
        else
            send_byte(cur.address_command);
        if (flaw == FLAW_CTRL_FLAG)
        begin
            send_byte(FLAG_BYTE);
            send_byte(cur.address_command);
        end
        send_byte(ctrl);
        if (flaw == FLAW_BCC1_FLAG)
        begin
            send_byte(FLAG_BYTE);
            send_byte(cur.address_command);
            send_byte(ctrl);
        end
        if (flaw == FLAW_BCC1)
            send_byte(cur.address_command ^ ctrl ^ (8'h01 << $urandom_range(0, 7)));
        else
            send_byte(cur.address_command ^ ctrl);
        if (flaw != FLAW_EMPTY)
        begin
            for (int i = 0; i <= len; i++)
            begin
                if (flaw == FLAW_BAD_ESCAPE && i == cut)
                begin
                    do
                        d = BYTE_W'($urandom_range(0, 255));
                    while (d == ESC_FLAG || d == ESC_ESC || d == FLAG_BYTE);
                    send_byte(ESC_BYTE);
                    send_byte(d);
                end
                if (i < len)
                begin
                    d = pick_data();
                    sum = sum ^ d;
                    send_stuffed(d);
                end
            end
            if (flaw == FLAW_ESCAPE_FLAG)
                send_byte(ESC_BYTE);
            else if (flaw == FLAW_BCC2)
                send_stuffed(sum ^ (8'h01 << $urandom_range(0, 7)));
            else
                send_stuffed(sum);
        end
        send_byte(FLAG_BYTE);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_ADDRESS_COMMAND, s.address_command);
        write_reg(REG_CONTROL_SEQ0, s.control_seq0);
        write_reg(REG_CONTROL_SEQ1, s.control_seq1);
        write_reg(REG_READY_CODE0, s.ready_code0);
        write_reg(REG_READY_CODE1, s.ready_code1);
        write_reg(REG_REJECT_CODE0, s.reject_code0);
        write_reg(REG_REJECT_CODE1, s.reject_code1);
        cfg_valid <= 1'b0;
        cur = s;
    endtask

    function automatic logic [BYTE_W-1:0] code_byte();
        unique case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] framing_byte();
        logic [BYTE_W-1:0] v;
        v = code_byte();
        if (v == FLAG_BYTE && $urandom_range(0, 3) != 0)
            v = ~v;
        return v;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.address_command = framing_byte();
        s.control_seq0 = framing_byte();
        s.control_seq1 = ($urandom_range(0, 5) == 0) ? s.control_seq0 : framing_byte();
        s.ready_code0 = code_byte();
        s.ready_code1 = code_byte();
        s.reject_code0 = code_byte();
        s.reject_code1 = code_byte();
        return s;
    endfunction

    function automatic int random_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    endfunction

    initial
    begin
        int unsigned target;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(1'b0, 3, FLAW_NONE);
        send_frame(1'b0, 2, FLAW_NONE);
        send_frame(1'b1, 0, FLAW_NONE);
        for (int i = int'(FLAW_ADDRESS); i <= int'(FLAW_EMPTY); i++)
            send_frame(1'b1, 2, flaw_t'(i));
        settle();
        apply_settings('{8'h3E, 8'h40, 8'h40, 8'h00, 8'hFF, 8'hFF, 8'h00});
        send_frame(1'b0, 1, FLAW_NONE);
        send_frame(1'b1, 4, FLAW_NONE);
        settle();
        apply_settings('{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF});
        send_frame(1'b1, 2, FLAW_NONE);
        send_frame(1'b0, 5, FLAW_BCC2);
        send_frame(1'b0, 1, FLAW_NONE);

        target = bytes_sent + 600;
        while (bytes_sent < target)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
                apply_settings(random_settings());
            repeat ($urandom_range(4, 10))
            begin
                hasty = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0:
                        repeat ($urandom_range(1, 8)) send_byte(pick_data());
                    1, 2:
                        send_frame(tx_seq, random_len(),
                                   flaw_t'($urandom_range(int'(FLAW_ADDRESS),
                                                          int'(FLAW_EMPTY))));
                    default:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            tx_seq = ~tx_seq;
                        send_frame(tx_seq, random_len(), FLAW_NONE);
                    end
                endcase
            end
        end

        settle();
        apply_settings('{8'h5A, 8'h10, 8'h32, 8'hA5, 8'h3C, 8'hC3, 8'h96});
        hasty = 1'b1;
        tx_seq = ~tx_seq;
        send_frame(tx_seq, MAX_PAYLOAD_DEF, FLAW_NONE);
        tx_seq = ~tx_seq;
        send_frame(tx_seq, MAX_PAYLOAD_DEF + 6, FLAW_NONE);
        settle();

        if (mismatches == 0)
            $display("info_frame_receiver_destuffer_unit verification clean");
        else
            $display("info_frame_receiver_destuffer_unit verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ifrd_pkg.sv
rtl/ifrd_cfg_regs.sv
rtl/ifrd_parser.sv
rtl/ifrd_out_reg.sv
rtl/info_frame_receiver_destuffer_unit.sv
tb/frame_verdict_checker.sv
tb/tb.sv
